// File: hdl/bhpq_pkg.sv
package bhpq_pkg;

    // fixed port widths
    localparam int KEY_PORT_W = 32;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int STATUS_W   = 2;

    // item kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER    = 1'd1;

    // controller -> datapath
    typedef struct packed {
        logic                ins_start;   // load key, open slot at end
        logic                rem_start;   // read root and last, shrink count
        logic                set_res;     // flag a rejected item
        logic [STATUS_W-1:0] res_status;
        logic                rd_parent;   // sift-up: read parent of hole
        logic                move_up;     // parent drops into hole
        logic                rem_take;    // latch root, carry last key
        logic                rd_children; // sift-down: read both children
        logic                move_down;   // best child rises into hole
        logic                write_cur;   // carried key lands in hole
        logic                load_out;    // result into output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic empty;
        logic at_root;
        logic up_swap;
        logic dn_move;
    } t_stat;

endpackage

// File: hdl/bhpq_ctrl.sv
module bhpq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_kind,
    input  logic            i_out_stall,
    input  bhpq_pkg::t_stat i_stat,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output bhpq_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_UP_CHK   = 3'd1;
    localparam logic [2:0] S_UP_CMP   = 3'd2;
    localparam logic [2:0] S_REM_LOAD = 3'd3;
    localparam logic [2:0] S_DN_RD    = 3'd4;
    localparam logic [2:0] S_DN_CMP   = 3'd5;
    localparam logic [2:0] S_FINISH   = 3'd6;

    logic [2:0]     r_state, n_state;
    logic           r_out_valid, n_out_valid;
    logic           out_free;
    bhpq_pkg::t_cmd cmd;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_kind == bhpq_pkg::KIND_INSERT) begin
                        if (i_stat.full) begin
                            cmd.set_res    = 1'b1;
                            cmd.res_status = bhpq_pkg::ST_FULL;
                            n_state        = S_FINISH;
                        end else begin
                            cmd.ins_start = 1'b1;
                            n_state       = S_UP_CHK;
                        end
                    end else begin
                        if (i_stat.empty) begin
                            cmd.set_res    = 1'b1;
                            cmd.res_status = bhpq_pkg::ST_EMPTY;
                            n_state        = S_FINISH;
                        end else begin
                            cmd.rem_start = 1'b1;
                            n_state       = S_REM_LOAD;
                        end
                    end
                end
            end
            S_UP_CHK: begin
                if (i_stat.at_root) begin
                    cmd.write_cur = 1'b1;
                    n_state       = S_FINISH;
                end else begin
                    cmd.rd_parent = 1'b1;
                    n_state       = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_stat.up_swap) begin
                    cmd.move_up = 1'b1;
                    n_state     = S_UP_CHK;
                end else begin
                    cmd.write_cur = 1'b1;
                    n_state       = S_FINISH;
                end
            end
            S_REM_LOAD: begin
                cmd.rem_take = 1'b1;
                // count already dropped: heap now empty means nothing to sift
                n_state = i_stat.empty ? S_FINISH : S_DN_RD;
            end
            S_DN_RD: begin
                cmd.rd_children = 1'b1;
                n_state         = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (i_stat.dn_move) begin
                    cmd.move_down = 1'b1;
                    n_state       = S_DN_RD;
                end else begin
                    cmd.write_cur = 1'b1;
                    n_state       = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten while stalled");

    // at most one memory write per cycle
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.write_cur, cmd.move_up, cmd.move_down}))
        else $error("conflicting heap writes");

    // an item in progress always closes through the finish state
    a_finish_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.write_cur || cmd.set_res) |=> (r_state == S_FINISH))
        else $error("item closed without finish");

    // a read is always followed by its compare
    a_read_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.rd_parent || cmd.rd_children) |=>
            (r_state == S_UP_CMP || r_state == S_DN_CMP))
        else $error("memory read not consumed");

endmodule

// File: hdl/bhpq_dp.sv
module bhpq_dp #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32,
    parameter int CNT_W     = $clog2(CAPACITY + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [bhpq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bhpq_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [bhpq_pkg::KEY_PORT_W-1:0]     i_key_in,
    input  bhpq_pkg::t_cmd                      i_cmd,
    output bhpq_pkg::t_stat                     o_stat,
    output logic [bhpq_pkg::KEY_PORT_W-1:0]     o_removed_key,
    output logic [bhpq_pkg::STATUS_W-1:0]       o_result_status,
    output logic [CNT_W-1:0]                    o_count_after
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CHD_W = IDX_W + 2;
    localparam int CMP_W = (CNT_W > bhpq_pkg::CFG_DATA_W) ? CNT_W : bhpq_pkg::CFG_DATA_W;

    logic [KEY_WIDTH-1:0] r_mem [CAPACITY];

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_limit;
    logic                 r_largest;
    logic [IDX_W-1:0]     r_pos;
    logic [KEY_WIDTH-1:0] r_cur;
    logic [KEY_WIDTH-1:0] r_rd0;
    logic [KEY_WIDTH-1:0] r_rd1;
    logic [KEY_WIDTH-1:0] r_res_key;
    logic [bhpq_pkg::STATUS_W-1:0] r_res_status;
    logic [bhpq_pkg::KEY_PORT_W-1:0] r_out_key;
    logic [bhpq_pkg::STATUS_W-1:0]   r_out_status;
    logic [CNT_W-1:0]                r_out_count;

    logic [IDX_W-1:0]     parent;
    logic [CHD_W-1:0]     left, right, n_ext;
    logic                 left_ok, right_ok, take_l, take_r;
    logic [KEY_WIDTH-1:0] best_l, wr_data;
    logic [IDX_W-1:0]     rd_addr0, rd_addr1;
    logic                 wr_en;
    logic [CMP_W-1:0]     cfg_v, cfg_clamp;

    function automatic logic key_precedes(input logic [KEY_WIDTH-1:0] a,
                                          input logic [KEY_WIDTH-1:0] b,
                                          input logic largest);
        key_precedes = largest ? (a > b) : (a < b);
    endfunction

    // heap index arithmetic
    assign parent = IDX_W'((r_pos - 1'b1) >> 1);
    assign left   = {1'b0, r_pos, 1'b1};
    assign right  = left + CHD_W'(1);
    assign n_ext  = CHD_W'(r_count);

    // sift-down choice: left only if strictly ahead, right only if ahead of that
    assign left_ok  = left < n_ext;
    assign right_ok = right < n_ext;
    assign take_l   = left_ok && key_precedes(r_rd0, r_cur, r_largest);
    assign best_l   = take_l ? r_rd0 : r_cur;
    assign take_r   = right_ok && key_precedes(r_rd1, best_l, r_largest);

    assign rd_addr0 = i_cmd.rem_start ? '0 :
                      i_cmd.rd_parent ? parent : left[IDX_W-1:0];
    assign rd_addr1 = i_cmd.rem_start ? IDX_W'(r_count - 1'b1) : right[IDX_W-1:0];

    assign wr_en   = i_cmd.write_cur || i_cmd.move_up || i_cmd.move_down;
    assign wr_data = i_cmd.write_cur ? r_cur :
                     i_cmd.move_up   ? r_rd0 :
                     take_r          ? r_rd1 : r_rd0;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_pos] <= wr_data;
        end
        r_rd0 <= r_mem[rd_addr0];
        r_rd1 <= r_mem[rd_addr1];
    end

    // capacity register: zero acts as one, above build size acts as build size
    always_comb begin
        cfg_v = CMP_W'(i_cfg_data);
        if (cfg_v == '0) begin
            cfg_clamp = CMP_W'(1);
        end else if (cfg_v > CMP_W'(CAPACITY)) begin
            cfg_clamp = CMP_W'(CAPACITY);
        end else begin
            cfg_clamp = cfg_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_limit   <= CNT_W'(CAPACITY);
            r_largest <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    bhpq_pkg::CFG_CAPACITY: r_limit   <= CNT_W'(cfg_clamp);
                    bhpq_pkg::CFG_ORDER:    r_largest <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.ins_start) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end else if (i_cmd.rem_start) begin
                r_count <= CNT_W'(r_count - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_start) begin
            r_cur        <= KEY_WIDTH'(i_key_in);
            r_pos        <= IDX_W'(r_count);
            r_res_key    <= '0;
            r_res_status <= bhpq_pkg::ST_DONE;
        end
        if (i_cmd.rem_start) begin
            r_res_key    <= '0;
            r_res_status <= bhpq_pkg::ST_DONE;
        end
        if (i_cmd.set_res) begin
            r_res_key    <= '0;
            r_res_status <= i_cmd.res_status;
        end
        if (i_cmd.rem_take) begin
            r_res_key <= r_rd0;
            r_cur     <= r_rd1;
            r_pos     <= '0;
        end
        if (i_cmd.move_up) begin
            r_pos <= parent;
        end
        if (i_cmd.move_down) begin
            r_pos <= take_r ? right[IDX_W-1:0] : left[IDX_W-1:0];
        end
        if (i_cmd.load_out) begin
            r_out_key    <= bhpq_pkg::KEY_PORT_W'(r_res_key);
            r_out_status <= r_res_status;
            r_out_count  <= r_count;
        end
    end

    assign o_stat.full    = (r_count >= r_limit);
    assign o_stat.empty   = (r_count == '0);
    assign o_stat.at_root = (r_pos == '0);
    assign o_stat.up_swap = key_precedes(r_cur, r_rd0, r_largest);
    assign o_stat.dn_move = take_l || take_r;

    assign o_removed_key   = r_out_key;
    assign o_result_status = r_out_status;
    assign o_count_after   = r_out_count;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_limit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_limit != '0) && (r_limit <= CNT_W'(CAPACITY)))
        else $error("capacity limit out of range");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_start |-> (r_count < r_limit))
        else $error("insert started on full heap");

endmodule

// File: hdl/binary_heap_priority_queue_unit.sv
// Binary heap priority queue of unsigned keys.
// Input channel (i_in_valid / o_in_stall): one transfer is one item, i_kind
// selects insert of i_key_in or removal of the root key. Output channel
// (o_out_valid / i_out_stall): exactly one result per item, in item order,
// carrying the removed key (zero unless a remove succeeded), a status (done,
// remove on empty, insert dropped because full) and the count after the item.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 sets the
// capacity limit (0 acts as 1, above CAPACITY acts as CAPACITY), index 1
// picks largest-first order. Write it only while the queue is idle.
// Timing: one item at a time. Rejected items go straight to the finish step
// and then to the output register. Each heap level moved by an insert or a
// remove costs one key-memory read and one compare-and-write.
// The result sits in an output register; the next item is taken while it
// waits, and is held in its finish step only if the register is still full.
// Reset (synchronous, active low) empties the heap, sets the limit to
// CAPACITY and smallest-first order; key memory is not cleared, only entries
// below the count are ever used.
module binary_heap_priority_queue_unit #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32,
    localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item input
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_kind,
    input  logic [bhpq_pkg::KEY_PORT_W-1:0]     i_key_in,
    // result output
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [bhpq_pkg::KEY_PORT_W-1:0]     o_removed_key,
    output logic [bhpq_pkg::STATUS_W-1:0]       o_result_status,
    output logic [CNT_W-1:0]                    o_count_after,
    // register writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bhpq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bhpq_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    bhpq_pkg::t_cmd  cmd;
    bhpq_pkg::t_stat stat;

    // registers are plain flops, a write always lands
    assign o_cfg_ready = 1'b1;

    // sequencer: one state per memory access of the sift
    bhpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_kind),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // key memory, count, config and result registers
    bhpq_dp #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH),
        .CNT_W     (CNT_W)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_key_in        (i_key_in),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_removed_key   (o_removed_key),
        .o_result_status (o_result_status),
        .o_count_after   (o_count_after)
    );

endmodule
